>>> rtl/bitmap_attribute_cell_render_core_defines.svh
// assertion macros shared by the render core
`ifndef BITMAP_ATTRIBUTE_CELL_RENDER_CORE_DEFINES_SVH
`define BITMAP_ATTRIBUTE_CELL_RENDER_CORE_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define BACR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked during reset as well
`define BACR_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bacr_pkg.sv
package bacr_pkg;

   // video memory geometry
   localparam int VMEM_DEPTH  = 6912;
   localparam int ADDR_W      = 13;
   localparam logic [ADDR_W-1:0] ATTR_BASE = 13'h1800;
   localparam int WIN_LINES   = 192;
   localparam int WIN_CELLS   = 32;
   localparam int NUM_PIXELS  = 8;

   // screen border defaults
   localparam int HBORDER_CELLS_DEFAULT = 4;
   localparam int VBORDER_LINES_DEFAULT = 24;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // request op codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_FRAME  = 2'd1;
   localparam logic [1:0] OP_RENDER = 2'd2;

   typedef logic [3:0] pixel_type;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_FRAME,
      KIND_BORDER,
      KIND_CELL
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] addr;      // write address or bitmap address
      logic [7:0]        data;
      logic [ADDR_W-1:0] att_addr;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ATTR,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/bacr_req_if.sv
interface bacr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [12:0] mem_address;
   logic [7:0] mem_data;
   logic [7:0] screen_line;
   logic [5:0] cell_column;

   modport source (output valid, op, mem_address, mem_data, screen_line, cell_column,
                   input ready);
   modport sink (input valid, op, mem_address, mem_data, screen_line, cell_column,
                 output ready);
endinterface

>>> rtl/bacr_rsp_if.sv
interface bacr_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] pixel_0;
   logic [3:0] pixel_1;
   logic [3:0] pixel_2;
   logic [3:0] pixel_3;
   logic [3:0] pixel_4;
   logic [3:0] pixel_5;
   logic [3:0] pixel_6;
   logic [3:0] pixel_7;

   modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                   pixel_6, pixel_7, input ready);
   modport sink (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                 pixel_6, pixel_7, output ready);
endinterface

>>> rtl/bacr_front.sv
module bacr_front import bacr_pkg::*; #(
   parameter int HBORDER_CELLS = HBORDER_CELLS_DEFAULT,
   parameter int VBORDER_LINES = VBORDER_LINES_DEFAULT
) (
   bacr_req_if.sink     req_chan,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   localparam logic [8:0] LINE_LO = 9'(VBORDER_LINES);
   localparam logic [8:0] LINE_HI = 9'(VBORDER_LINES + WIN_LINES);
   localparam logic [6:0] CELL_LO = 7'(HBORDER_CELLS);
   localparam logic [6:0] CELL_HI = 7'(HBORDER_CELLS + WIN_CELLS);

   logic              in_window;
   logic              keep;
   logic [7:0]        row;
   logic [5:0]        col_full;
   logic [4:0]        col;
   logic [ADDR_W-1:0] bmp_addr;
   logic [ADDR_W-1:0] att_addr;

   // window check and interleaved addresses
   always_comb begin
      in_window = ({1'b0, req_chan.screen_line} >= LINE_LO) &&
                  ({1'b0, req_chan.screen_line} <  LINE_HI) &&
                  ({1'b0, req_chan.cell_column} >= CELL_LO) &&
                  ({1'b0, req_chan.cell_column} <  CELL_HI);
      row       = req_chan.screen_line - 8'(VBORDER_LINES);
      col_full  = req_chan.cell_column - 6'(HBORDER_CELLS);
      col       = col_full[4:0];
      bmp_addr  = {row[7:6], row[2:0], row[5:3], col};
      att_addr  = ATTR_BASE + {3'b000, row[7:3], col};
   end

   // classify the request
   always_comb begin
      keep              = 1'b0;
      push_cmd.kind     = KIND_WRITE;
      push_cmd.addr     = req_chan.mem_address;
      push_cmd.data     = req_chan.mem_data;
      push_cmd.att_addr = att_addr;
      case (req_chan.op)
         OP_WRITE: begin
            keep = (req_chan.mem_address < 13'(VMEM_DEPTH));
         end
         OP_FRAME: begin
            keep          = 1'b1;
            push_cmd.kind = KIND_FRAME;
         end
         OP_RENDER: begin
            keep          = 1'b1;
            push_cmd.kind = in_window ? KIND_CELL : KIND_BORDER;
            push_cmd.addr = bmp_addr;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // unused ops and out-of-range writes are taken and dropped
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full && keep;

endmodule

>>> rtl/bacr_queue.sv
module bacr_queue import bacr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

>>> rtl/bacr_back.sv
module bacr_back import bacr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      head,
   input  q_status_type q_status,
   input  logic [3:0]   border_colour,
   output logic         pop,
   bacr_rsp_if.source   rsp_chan
);

   state_type         state_ff, state_in;
   logic [4:0]        flash_ff, flash_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] att_addr_ff;
   logic [7:0]        bits_ff;
   logic [7:0]        rdata_ff;
   pixel_type         pixel_ff [NUM_PIXELS];
   pixel_type         pixel_in [NUM_PIXELS];
   logic [7:0]        vmem [VMEM_DEPTH];

   logic              can_load;
   logic              finish;
   logic              issue_ok;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic              load_border;
   logic              flash_step;
   logic              start_cell;
   pixel_type         fore;
   pixel_type         back;

   // issue, memory port and result control
   always_comb begin
      can_load    = !rsp_valid_ff || rsp_chan.ready;
      finish      = (state_ff == ST_FINISH) && can_load;
      issue_ok    = (state_ff == ST_IDLE) || finish;
      pop         = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = head.addr;
      load_border = 1'b0;
      flash_step  = 1'b0;
      start_cell  = 1'b0;
      if (state_ff == ST_ATTR) begin
         mem_re   = 1'b1;
         mem_addr = att_addr_ff;
      end else if (issue_ok && !q_status.empty) begin
         case (head.kind)
            KIND_WRITE: begin
               pop    = 1'b1;
               mem_we = 1'b1;
            end
            KIND_FRAME: begin
               pop        = 1'b1;
               flash_step = 1'b1;
            end
            KIND_BORDER: begin
               // output slot is free for it only when no cell is finishing
               if (state_ff == ST_IDLE && can_load) begin
                  pop         = 1'b1;
                  load_border = 1'b1;
               end
            end
            KIND_CELL: begin
               pop        = 1'b1;
               mem_re     = 1'b1;
               start_cell = 1'b1;
            end
            default: begin
               pop = 1'b0;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_cell) begin
               state_in = ST_ATTR;
            end
         end
         ST_ATTR: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish) begin
               state_in = start_cell ? ST_ATTR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ink and paper with flash swap, one index per bitmap bit
   always_comb begin
      fore = {rdata_ff[6], rdata_ff[2:0]};
      back = rdata_ff[6:3];
      if (rdata_ff[7] && !flash_ff[4]) begin
         fore = rdata_ff[6:3];
         back = {rdata_ff[6], rdata_ff[2:0]};
      end
      for (int i = 0; i < NUM_PIXELS; i++) begin
         if (load_border) begin
            pixel_in[i] = border_colour;
         end else begin
            pixel_in[i] = bits_ff[NUM_PIXELS-1-i] ? fore : back;
         end
      end
   end

   // control registers
   always_comb begin
      flash_in     = flash_step ? flash_ff + 1'b1 : flash_ff;
      rsp_valid_in = rsp_valid_ff;
      if (finish || load_border) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flash_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flash_ff     <= flash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start_cell) begin
         att_addr_ff <= head.att_addr;
      end
      if (state_ff == ST_ATTR) begin
         bits_ff <= rdata_ff;
      end
      if (finish || load_border) begin
         for (int i = 0; i < NUM_PIXELS; i++) begin
            pixel_ff[i] <= pixel_in[i];
         end
      end
   end

   // single-port video memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[mem_addr] <= head.data;
      end
      if (mem_re) begin
         rdata_ff <= vmem[mem_addr];
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.pixel_0 = pixel_ff[0];
   assign rsp_chan.pixel_1 = pixel_ff[1];
   assign rsp_chan.pixel_2 = pixel_ff[2];
   assign rsp_chan.pixel_3 = pixel_ff[3];
   assign rsp_chan.pixel_4 = pixel_ff[4];
   assign rsp_chan.pixel_5 = pixel_ff[5];
   assign rsp_chan.pixel_6 = pixel_ff[6];
   assign rsp_chan.pixel_7 = pixel_ff[7];

endmodule

>>> rtl/bitmap_attribute_cell_render_core.sv
// Cell renderer for a bitmap-plus-attribute screen: 6912 bytes of video memory (6144 bitmap
// bytes in interleaved line order, then 768 attribute bytes) are filled by write requests, a
// frame-start request steps a 5-bit flash counter, and a render request returns eight 4-bit
// palette indices for one 8-pixel cell, border colour outside the 256x192 window. Requests
// pass a decoder into a two-entry queue, so the request side keeps moving while the video
// memory side works. The video memory is one single-port RAM: a write takes one access,
// a frame start or a border cell none, a window cell two reads (bitmap, then attribute);
// the next window cell's bitmap read is issued alongside the previous cell's result load
// when the output register is free. A result sits in an output register until taken; a
// window cell passes the queue, the bitmap read, the attribute read and the output register,
// a border cell the queue and the output register. Memory bytes never written read unknown.
`include "bitmap_attribute_cell_render_core_defines.svh"

module bitmap_attribute_cell_render_core import bacr_pkg::*; #(
   parameter int HBORDER_CELLS = HBORDER_CELLS_DEFAULT,
   parameter int VBORDER_LINES = VBORDER_LINES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bacr_req_if.sink   req_chan,
   bacr_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data
);

   logic         push;
   logic         pop;
   cmd_type      push_cmd;
   cmd_type      head;
   q_status_type q_status;
   logic [3:0]   border_colour_ff, border_colour_in;

   // border colour register
   assign border_colour_in = csr_write_enable ? csr_write_data : border_colour_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         border_colour_ff <= '0;
      end else begin
         border_colour_ff <= border_colour_in;
      end
   end

   // request decode
   bacr_front #(
      .HBORDER_CELLS (HBORDER_CELLS),
      .VBORDER_LINES (VBORDER_LINES)
   ) u_front (
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // command queue
   bacr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // memory and pixel side
   bacr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .border_colour (border_colour_ff),
      .pop           (pop),
      .rsp_chan      (rsp_chan)
   );

   // queue sanity
   `BACR_ASSERT_IMP(a_no_push_when_full, clock, reset, push, !q_status.full, "push into full queue")
   `BACR_ASSERT_IMP(a_no_pop_when_empty, clock, reset, pop, !q_status.empty, "pop from empty queue")
   `BACR_ASSERT_NEXT(a_empty_after_reset, clock, reset, q_status.empty && !rsp_chan.valid, "not clear after reset")

endmodule
